// ===== hdl/rvfs_pkg.sv =====
// shared constants, codes and types for the voronoi ray facet search
package rvfs_pkg;

  // number format and field widths
  localparam int INDEX_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int LEN_BITS   = 48;
  localparam int LIMIT_BITS = LEN_BITS - 1;
  // anchor minus candidate term
  localparam int DIFF_BITS  = LEN_BITS + 1;
  // bisector numerator and denominator, signed
  localparam int NUM_BITS   = DIFF_BITS + 2;
  localparam int DEN_BITS   = DIFF_BITS + 1;
  // magnitudes fed to the divider
  localparam int MAGN_BITS  = NUM_BITS - 1;
  localparam int MAGD_BITS  = DEN_BITS - 1;
  // dividend is the numerator magnitude scaled by the fraction
  localparam int DIVD_BITS  = MAGN_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(DIVD_BITS);

  localparam logic signed [LEN_BITS-1:0] LEN_MAX = {1'b0, {(LEN_BITS-1){1'b1}}};
  localparam logic signed [LEN_BITS-1:0] LEN_MIN = {1'b1, {(LEN_BITS-1){1'b0}}};

  // item actions
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_CAND   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // search modes
  localparam logic [1:0] MODE_RAY  = 2'd0;
  localparam logic [1:0] MODE_ANY  = 2'd1;
  localparam logic [1:0] MODE_LINE = 2'd2;

  // top level sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIFF,
    S_PREP,
    S_WAIT
  } seq_state_t;

  // divider sequencer
  typedef enum logic [1:0] {
    D_IDLE,
    D_ABS,
    D_RUN,
    D_FIX
  } div_state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/rvfs_if.sv =====
// valid/ready channels for input items and result items

interface rvfs_in_if import rvfs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [1:0]                    mode;
  logic signed [LEN_BITS-1:0]    anchor_norm_sq;
  logic signed [LEN_BITS-1:0]    anchor_dot_dir;
  logic signed [LEN_BITS-1:0]    anchor_dot_origin;
  logic [LIMIT_BITS-1:0]         fwd_limit;
  logic [LIMIT_BITS-1:0]         bwd_limit;
  logic [INDEX_BITS-1:0]         cand_index;
  logic signed [LEN_BITS-1:0]    cand_norm_sq;
  logic signed [LEN_BITS-1:0]    cand_dot_dir;
  logic signed [LEN_BITS-1:0]    cand_dot_origin;
  logic                          cand_ignored;

  modport source (
    output valid, action, mode, anchor_norm_sq, anchor_dot_dir, anchor_dot_origin,
           fwd_limit, bwd_limit, cand_index, cand_norm_sq, cand_dot_dir,
           cand_dot_origin, cand_ignored,
    input  ready
  );
  modport sink (
    input  valid, action, mode, anchor_norm_sq, anchor_dot_dir, anchor_dot_origin,
           fwd_limit, bwd_limit, cand_index, cand_norm_sq, cand_dot_dir,
           cand_dot_origin, cand_ignored,
    output ready
  );
endinterface

interface rvfs_out_if import rvfs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          primary_found;
  logic [INDEX_BITS-1:0]         primary_index;
  logic signed [LEN_BITS-1:0]    primary_length;
  logic                          second_found;
  logic [INDEX_BITS-1:0]         second_index;
  logic signed [LEN_BITS-1:0]    second_length;

  modport source (
    output valid, primary_found, primary_index, primary_length,
           second_found, second_index, second_length,
    input  ready
  );
  modport sink (
    input  valid, primary_found, primary_index, primary_length,
           second_found, second_index, second_length,
    output ready
  );
endinterface

// ===== hdl/ray_voronoi_facet_search.sv =====
// ray exit search over voronoi bisectors: start, candidate and finish items
// start items load the search state, finish items a registered result item;
// a candidate passes the difference and prep states, then the divider: load,
// one trial subtract per dividend bit, saturate, then the nearest-hit update
// one item at a time, held while a result waits undrained; ignored candidates
// leave the sequencer idle, parallel ones skip the divider; reset (synchronous,
// active high) clears sequencers, search state and out_valid; no clearing pass
module ray_voronoi_facet_search import rvfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rvfs_in_if.sink     in_ch,
  rvfs_out_if.source  out_ch
);

  seq_state_t state, state_next;

  // search state
  logic [1:0]                 mode_reg;
  logic signed [LEN_BITS-1:0] a_nsq, a_dir, a_org;
  logic signed [LEN_BITS-1:0] best_fwd_length, best_bwd_length;
  logic [INDEX_BITS-1:0]      best_fwd_index, best_bwd_index;
  logic                       fwd_hit, bwd_hit;

  // candidate in flight
  logic [INDEX_BITS-1:0]      c_idx;
  logic signed [LEN_BITS-1:0] c_nsq, c_dir, c_org;
  logic signed [DIFF_BITS-1:0] t_nsq, t_dir, t_org;
  logic                       den_neg;

  // result register
  logic                       out_valid;
  logic                       o_pf, o_sf;
  logic [INDEX_BITS-1:0]      o_pi, o_si;
  logic signed [LEN_BITS-1:0] o_pl, o_sl;

  logic                       in_ready;
  logic                       accept;
  logic                       div_start;
  logic signed [NUM_BITS-1:0] num;
  logic signed [DEN_BITS-1:0] den;
  logic                       parallel;
  div_stat_t                  div_stat;
  logic signed [LEN_BITS-1:0] quot;

  // finish selection
  logic                       pf, sf;
  logic [INDEX_BITS-1:0]      pi, si;
  logic signed [LEN_BITS-1:0] pl, sl;

  assign accept = in_ch.valid & in_ready;

  // bisector terms from the registered differences
  always_comb begin
    num = {{2{t_nsq[DIFF_BITS-1]}}, t_nsq} - {t_org[DIFF_BITS-1], t_org, 1'b0};
    den = {t_dir, 1'b0};
    parallel = (t_dir == '0);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && in_ch.action == ACT_CAND && !in_ch.cand_ignored)
                state_next = S_DIFF;
      S_DIFF: state_next = S_PREP;
      S_PREP: state_next = parallel ? S_IDLE : S_WAIT;
      S_WAIT: if (div_stat.done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = (state == S_IDLE) && (!out_valid || out_ch.ready);
    div_start = (state == S_PREP) && !parallel;
  end

  // finish result by mode
  always_comb begin
    pf = fwd_hit;
    pi = best_fwd_index;
    pl = best_fwd_length;
    sf = 1'b0;
    si = '0;
    sl = '0;
    priority if (mode_reg == MODE_ANY && !fwd_hit) begin
      pf = bwd_hit;
      pi = best_bwd_index;
      pl = best_bwd_length;
    end else if (mode_reg == MODE_LINE) begin
      sf = bwd_hit;
      si = best_bwd_index;
      sl = best_bwd_length;
    end
  end

  rvfs_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .stat  (div_stat),
    .quot  (quot)
  );

  // control and search state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      mode_reg        <= MODE_RAY;
      a_nsq           <= '0;
      a_dir           <= '0;
      a_org           <= '0;
      best_fwd_length <= '0;
      best_fwd_index  <= '0;
      fwd_hit         <= 1'b0;
      best_bwd_length <= '0;
      best_bwd_index  <= '0;
      bwd_hit         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      // a finish item loads the result register, ready drains it
      if (accept && in_ch.action == ACT_FINISH) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      // start items
      if (accept && in_ch.action == ACT_START) begin
        mode_reg        <= in_ch.mode;
        a_nsq           <= in_ch.anchor_norm_sq;
        a_dir           <= in_ch.anchor_dot_dir;
        a_org           <= in_ch.anchor_dot_origin;
        best_fwd_length <= $signed({1'b0, in_ch.fwd_limit});
        best_bwd_length <= -$signed({1'b0, in_ch.bwd_limit});
        best_fwd_index  <= '0;
        best_bwd_index  <= '0;
        fwd_hit         <= 1'b0;
        bwd_hit         <= 1'b0;
      end
      // keep the nearest crossing on each side
      if (state == S_WAIT && div_stat.done) begin
        if (den_neg && quot < best_fwd_length) begin
          best_fwd_length <= quot;
          best_fwd_index  <= c_idx;
          fwd_hit         <= 1'b1;
        end
        if (!den_neg && quot > best_bwd_length) begin
          best_bwd_length <= quot;
          best_bwd_index  <= c_idx;
          bwd_hit         <= 1'b1;
        end
      end
    end
  end

  // candidate and result payload
  always_ff @(posedge clk) begin
    if (accept && in_ch.action == ACT_CAND) begin
      c_idx <= in_ch.cand_index;
      c_nsq <= in_ch.cand_norm_sq;
      c_dir <= in_ch.cand_dot_dir;
      c_org <= in_ch.cand_dot_origin;
    end
    if (state == S_DIFF) begin
      t_nsq <= DIFF_BITS'(a_nsq) - DIFF_BITS'(c_nsq);
      t_dir <= DIFF_BITS'(a_dir) - DIFF_BITS'(c_dir);
      t_org <= DIFF_BITS'(a_org) - DIFF_BITS'(c_org);
    end
    if (state == S_PREP) den_neg <= t_dir[DIFF_BITS-1];
    if (accept && in_ch.action == ACT_FINISH) begin
      o_pf <= pf;
      o_pi <= pf ? pi : '0;
      o_pl <= pl;
      o_sf <= sf;
      o_si <= sf ? si : '0;
      o_sl <= sl;
    end
  end

  // ports
  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.primary_found  = o_pf;
  assign out_ch.primary_index  = o_pi;
  assign out_ch.primary_length = o_pl;
  assign out_ch.second_found   = o_sf;
  assign out_ch.second_index   = o_si;
  assign out_ch.second_length  = o_sl;

endmodule

// ===== hdl/rvfs_divider.sv =====
// bit-serial signed divider with fraction scaling and saturation
module rvfs_divider import rvfs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [NUM_BITS-1:0]  num,
  input  logic signed [DEN_BITS-1:0]  den,
  output div_stat_t                   stat,
  output logic signed [LEN_BITS-1:0]  quot
);

  div_state_t state, state_next;

  logic signed [NUM_BITS-1:0] num_r;
  logic signed [DEN_BITS-1:0] den_r;
  logic                       neg;
  logic [DIVD_BITS-1:0]       dvd;
  logic [MAGD_BITS-1:0]       dsr;
  logic [MAGD_BITS-1:0]       rem;
  logic [LEN_BITS-1:0]        q;
  logic                       sticky;
  logic [CNT_BITS-1:0]        cnt;
  logic                       done;

  logic [NUM_BITS-1:0]        n_mag;
  logic [DEN_BITS-1:0]        d_mag;
  logic [MAGD_BITS:0]         r_sh;
  logic [MAGD_BITS:0]         r_sub;
  logic                       ge;
  logic                       last;
  logic                       sat;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: if (start) state_next = D_ABS;
      D_ABS:  state_next = D_RUN;
      D_RUN:  if (last) state_next = D_FIX;
      D_FIX:  state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  // step datapath: magnitudes, one trial subtract, saturation
  always_comb begin
    n_mag = num_r[NUM_BITS-1] ? (-num_r) : num_r;
    d_mag = den_r[DEN_BITS-1] ? (-den_r) : den_r;
    r_sh  = {rem, dvd[DIVD_BITS-1]};
    r_sub = r_sh - {1'b0, dsr};
    ge    = (r_sh >= {1'b0, dsr});
    last  = (cnt == CNT_BITS'(DIVD_BITS - 1));
    sat   = sticky | q[LEN_BITS-1];
    stat.busy = (state != D_IDLE);
    stat.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == D_FIX);
    end
  end

  // operand and iteration registers
  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        if (start) begin
          num_r <= num;
          den_r <= den;
        end
      end
      D_ABS: begin
        neg    <= num_r[NUM_BITS-1] ^ den_r[DEN_BITS-1];
        dvd    <= {n_mag[MAGN_BITS-1:0], {FRAC_BITS{1'b0}}};
        dsr    <= d_mag[MAGD_BITS-1:0];
        rem    <= '0;
        q      <= '0;
        sticky <= 1'b0;
        cnt    <= '0;
      end
      D_RUN: begin
        rem    <= ge ? r_sub[MAGD_BITS-1:0] : r_sh[MAGD_BITS-1:0];
        dvd    <= {dvd[DIVD_BITS-2:0], 1'b0};
        q      <= {q[LEN_BITS-2:0], ge};
        sticky <= sticky | q[LEN_BITS-1];
        cnt    <= cnt + 1'b1;
      end
      D_FIX: begin
        if (neg) quot <= sat ? LEN_MIN : -$signed(q);
        else     quot <= sat ? LEN_MAX : $signed(q);
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/ray_voronoi_facet_search_test.sv =====
// testbench for the voronoi ray facet search: queued stimulus, predictor and result checks
`timescale 1ns / 100ps

module ray_voronoi_facet_search_test;
  import rvfs_pkg::*;

  // codes the block has no name for
  localparam logic [1:0] ACT_VOID   = 2'd3;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  localparam logic signed [LEN_BITS-1:0] Q_ONE = 48'sd65536;
  localparam logic [LIMIT_BITS-1:0] LIMIT_TOP = '1;
  localparam logic [127:0] HALF_RANGE = 128'd1 << (LEN_BITS - 1);
  localparam int ITEM_TARGET  = 1250;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLDOFF_LEN  = 400;
  localparam int SETTLE_LEN   = 150;

  typedef struct {
    logic [1:0]                 action;
    logic [1:0]                 mode;
    logic signed [LEN_BITS-1:0] a_nsq;
    logic signed [LEN_BITS-1:0] a_dir;
    logic signed [LEN_BITS-1:0] a_org;
    logic [LIMIT_BITS-1:0]      fwd_lim;
    logic [LIMIT_BITS-1:0]      bwd_lim;
    logic [INDEX_BITS-1:0]      idx;
    logic signed [LEN_BITS-1:0] c_nsq;
    logic signed [LEN_BITS-1:0] c_dir;
    logic signed [LEN_BITS-1:0] c_org;
    logic                       ignored;
    logic                       drain;
  } search_item_t;

  typedef struct {
    logic                       p_found;
    logic [INDEX_BITS-1:0]      p_idx;
    logic signed [LEN_BITS-1:0] p_len;
    logic                       s_found;
    logic [INDEX_BITS-1:0]      s_idx;
    logic signed [LEN_BITS-1:0] s_len;
  } exit_result_t;

  logic clk;
  logic rst;

  rvfs_in_if  search_in ();
  rvfs_out_if search_out ();

  ray_voronoi_facet_search u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (search_in),
    .out_ch (search_out)
  );

  // pending stimulus and expected exits
  search_item_t search_q[$];
  exit_result_t exit_q[$];
  search_item_t cur_item;

  // predicted cell search state
  logic [1:0]                 cell_mode;
  logic signed [LEN_BITS-1:0] anc_nsq, anc_dir, anc_org;
  logic signed [LEN_BITS-1:0] near_fwd_len, near_bwd_len;
  logic [INDEX_BITS-1:0]      near_fwd_idx, near_bwd_idx;
  logic                       near_fwd_hit, near_bwd_hit;

  int n_planned, total_items, n_sent, idle_phase;
  int n_starts, n_cands, n_divs, n_sats, n_finishes, n_results, n_errors;
  int holdoff_left, stall_cycles;
  bit holdoff_used;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one line per mismatch, printing capped
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (n_errors < 40)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  // bisector crossing: trunc(num * 2^FRAC_BITS / den), saturated to 48 bits
  function automatic logic signed [LEN_BITS-1:0] bisector_length(longint num, longint den);
    logic [127:0] nmag, dmag, quo;
    logic         neg;
    neg  = (num < 0) != (den < 0);
    nmag = (num < 0) ? -num : num;
    dmag = (den < 0) ? -den : den;
    quo  = (nmag << FRAC_BITS) / dmag;
    if (quo >= HALF_RANGE)
      return neg ? LEN_MIN : LEN_MAX;
    if (neg)
      return -$signed(quo[LEN_BITS-1:0]);
    return $signed(quo[LEN_BITS-1:0]);
  endfunction

  function automatic void clear_search_state();
    cell_mode    = MODE_RAY;
    anc_nsq      = '0;
    anc_dir      = '0;
    anc_org      = '0;
    near_fwd_len = '0;
    near_bwd_len = '0;
    near_fwd_idx = '0;
    near_bwd_idx = '0;
    near_fwd_hit = 1'b0;
    near_bwd_hit = 1'b0;
  endfunction

  // advance the predicted state by one accepted item
  function automatic void track_search(search_item_t it);
    longint                     num, den;
    logic signed [LEN_BITS-1:0] len;
    exit_result_t               res;
    case (it.action)
      ACT_START: begin
        n_starts++;
        cell_mode    = it.mode;
        anc_nsq      = it.a_nsq;
        anc_dir      = it.a_dir;
        anc_org      = it.a_org;
        near_fwd_len = $signed({1'b0, it.fwd_lim});
        near_bwd_len = -$signed({1'b0, it.bwd_lim});
        near_fwd_idx = '0;
        near_bwd_idx = '0;
        near_fwd_hit = 1'b0;
        near_bwd_hit = 1'b0;
      end
      ACT_CAND: begin
        n_cands++;
        den = 2 * (longint'(anc_dir) - longint'(it.c_dir));
        // ignored and parallel candidates leave the hits alone
        if (!it.ignored && den != 0) begin
          num = longint'(anc_nsq) - longint'(it.c_nsq)
                - 2 * (longint'(anc_org) - longint'(it.c_org));
          len = bisector_length(num, den);
          n_divs++;
          if (len == LEN_MAX || len == LEN_MIN)
            n_sats++;
          if (den < 0 && len < near_fwd_len) begin
            near_fwd_len = len;
            near_fwd_idx = it.idx;
            near_fwd_hit = 1'b1;
          end
          if (den > 0 && len > near_bwd_len) begin
            near_bwd_len = len;
            near_bwd_idx = it.idx;
            near_bwd_hit = 1'b1;
          end
        end
      end
      ACT_FINISH: begin
        n_finishes++;
        res.p_found = near_fwd_hit;
        res.p_idx   = near_fwd_idx;
        res.p_len   = near_fwd_len;
        res.s_found = 1'b0;
        res.s_idx   = '0;
        res.s_len   = '0;
        // any mode falls back to the backward end; line mode reports both
        if (cell_mode == MODE_ANY && !near_fwd_hit) begin
          res.p_found = near_bwd_hit;
          res.p_idx   = near_bwd_idx;
          res.p_len   = near_bwd_len;
        end else if (cell_mode == MODE_LINE) begin
          res.s_found = near_bwd_hit;
          res.s_idx   = near_bwd_idx;
          res.s_len   = near_bwd_len;
        end
        if (!res.p_found)
          res.p_idx = '0;
        if (!res.s_found)
          res.s_idx = '0;
        exit_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // random values
  function automatic logic [LEN_BITS-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[LEN_BITS-1:0];
  endfunction

  function automatic logic signed [LEN_BITS-1:0] small_term();
    logic [19:0] s;
    s = $urandom();
    return {{(LEN_BITS-20){s[19]}}, s};
  endfunction

  function automatic logic signed [LEN_BITS-1:0] pick_term();
    int roll;
    roll = $urandom_range(9);
    if (roll < 6)
      return small_term();
    if (roll < 9)
      return rand_word();
    return ($urandom_range(1) != 0) ? LEN_MAX : LEN_MIN;
  endfunction

  function automatic logic [LIMIT_BITS-1:0] pick_limit();
    logic [LEN_BITS-1:0] w;
    w = rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return LIMIT_TOP;
      2: return w[LIMIT_BITS-1:0];
      default: return {17'd0, w[29:0]};
    endcase
  endfunction

  // every field but drain random, including the ones the action does not use
  function automatic search_item_t random_item();
    search_item_t it;
    it.action  = 2'($urandom_range(3));
    it.mode    = 2'($urandom_range(3));
    it.a_nsq   = rand_word();
    it.a_dir   = rand_word();
    it.a_org   = rand_word();
    it.fwd_lim = pick_limit();
    it.bwd_lim = pick_limit();
    it.idx     = INDEX_BITS'($urandom());
    it.c_nsq   = rand_word();
    it.c_dir   = rand_word();
    it.c_org   = rand_word();
    it.ignored = 1'($urandom_range(1));
    it.drain   = 1'b0;
    return it;
  endfunction

  function automatic search_item_t make_start(logic [1:0] mode,
      logic signed [LEN_BITS-1:0] nsq, logic signed [LEN_BITS-1:0] dir,
      logic signed [LEN_BITS-1:0] org, logic [LIMIT_BITS-1:0] fl,
      logic [LIMIT_BITS-1:0] bl);
    search_item_t it;
    it         = random_item();
    it.action  = ACT_START;
    it.mode    = mode;
    it.a_nsq   = nsq;
    it.a_dir   = dir;
    it.a_org   = org;
    it.fwd_lim = fl;
    it.bwd_lim = bl;
    return it;
  endfunction

  function automatic search_item_t make_cand(logic [INDEX_BITS-1:0] idx,
      logic signed [LEN_BITS-1:0] nsq, logic signed [LEN_BITS-1:0] dir,
      logic signed [LEN_BITS-1:0] org, logic ign);
    search_item_t it;
    it         = random_item();
    it.action  = ACT_CAND;
    it.idx     = idx;
    it.c_nsq   = nsq;
    it.c_dir   = dir;
    it.c_org   = org;
    it.ignored = ign;
    return it;
  endfunction

  function automatic search_item_t make_finish();
    search_item_t it;
    it        = random_item();
    it.action = ACT_FINISH;
    return it;
  endfunction

  // items the block only skips are not counted
  function automatic void push_item(search_item_t it);
    search_q.push_back(it);
    if (it.action != ACT_VOID && !(it.action == ACT_CAND && it.ignored))
      n_planned++;
  endfunction

  // stimulus, reset and end of run
  initial begin
    search_item_t st, ct, prev;
    bit           have_prev;
    int           roll, ncand, kind, drain_mark;

    search_in.valid             = 1'b0;
    search_in.action            = ACT_START;
    search_in.mode              = MODE_RAY;
    search_in.anchor_norm_sq    = '0;
    search_in.anchor_dot_dir    = '0;
    search_in.anchor_dot_origin = '0;
    search_in.fwd_limit         = '0;
    search_in.bwd_limit         = '0;
    search_in.cand_index        = '0;
    search_in.cand_norm_sq      = '0;
    search_in.cand_dot_dir      = '0;
    search_in.cand_dot_origin   = '0;
    search_in.cand_ignored      = 1'b0;
    search_out.ready            = 1'b0;
    rst                         = 1'b1;
    clear_search_state();

    // finish and candidate on the reset state
    push_item(make_finish());
    push_item(make_cand(16'd3, -4 * Q_ONE, Q_ONE, '0, 1'b0));
    push_item(make_finish());
    // any mode at the anchor extremes: ignored, parallel, extreme candidate
    push_item(make_start(MODE_ANY, LEN_MAX, LEN_MAX, LEN_MIN, LIMIT_TOP, LIMIT_TOP));
    push_item(make_cand(16'hFFFF, LEN_MIN, LEN_MIN, LEN_MIN, 1'b1));
    push_item(make_cand(16'h0001, LEN_MIN, LEN_MAX, LEN_MAX, 1'b0));
    push_item(make_cand(16'hFFFF, LEN_MIN, LEN_MIN, LEN_MIN, 1'b0));
    push_item(make_finish());
    // line mode: saturation both ways, then a tie that must not replace
    push_item(make_start(MODE_LINE, LEN_MAX, '0, '0, LIMIT_TOP, LIMIT_TOP));
    push_item(make_cand(16'd1, LEN_MIN, 48'sd1, '0, 1'b0));
    push_item(make_cand(16'd2, LEN_MIN, -48'sd1, '0, 1'b0));
    push_item(make_cand(16'd4, LEN_MIN, 48'sd1, '0, 1'b0));
    push_item(make_finish());
    push_item(make_finish());
    // undefined mode behaves as a forward ray, zero limits
    push_item(make_start(MODE_UNDEF, '0, '0, '0, '0, '0));
    push_item(make_cand(16'd0, -4 * Q_ONE, Q_ONE, '0, 1'b0));
    push_item(make_cand(16'd5, -4 * Q_ONE, -Q_ONE, '0, 1'b0));
    push_item(make_finish());
    // undefined action
    st = random_item();
    st.action = ACT_VOID;
    push_item(st);
    // any mode with no hit returns the backward limit
    push_item(make_start(MODE_ANY, '0, '0, '0, 47'd655360, 47'd655360));
    push_item(make_finish());
    // plain forward ray with one hit
    push_item(make_start(MODE_RAY, Q_ONE, '0, '0, LIMIT_TOP, '0));
    push_item(make_cand(16'h8000, -4 * Q_ONE, 2 * Q_ONE, Q_ONE, 1'b0));
    push_item(make_finish());

    // random search sequences with some noise and broken sequences
    have_prev  = 1'b0;
    drain_mark = 0;
    while (n_planned < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        push_item(random_item());
      end else begin
        st = make_start(($urandom_range(19) == 0) ? MODE_UNDEF : 2'($urandom_range(2)),
                        pick_term(), pick_term(), pick_term(), pick_limit(), pick_limit());
        if (n_planned >= drain_mark) begin
          st.drain   = 1'b1;
          drain_mark = (drain_mark < 600) ? 700 : 1 << 30;
        end
        push_item(st);
        have_prev = 1'b0;
        ncand     = $urandom_range(8);
        for (int i = 0; i < ncand; i++) begin
          kind = $urandom_range(19);
          if (kind == 0)
            ct = make_cand(INDEX_BITS'($urandom()), pick_term(), st.a_dir, pick_term(), 1'b0);
          else if (kind < 3 && have_prev)
            ct = make_cand(INDEX_BITS'($urandom()), prev.c_nsq, prev.c_dir, prev.c_org, 1'b0);
          else if (kind < 5)
            ct = make_cand(INDEX_BITS'($urandom()), pick_term(), pick_term(), pick_term(),
                           1'b0);
          else
            ct = make_cand(INDEX_BITS'($urandom()), st.a_nsq + small_term(),
                           st.a_dir + small_term(), st.a_org + small_term(), 1'b0);
          ct.ignored = ($urandom_range(11) == 0);
          push_item(ct);
          prev      = ct;
          have_prev = 1'b1;
        end
        if (roll >= 12)
          push_item(make_finish());
        if ($urandom_range(7) == 0)
          push_item(make_finish());
      end
    end
    total_items = search_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // drain, then let any late result show up
    while (search_q.size() != 0 || search_in.valid || exit_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);

    $display("covered %0d items: %0d starts, %0d candidates (%0d divisions, %0d saturated),",
             n_sent, n_starts, n_cands, n_divs, n_sats);
    $display("%0d finishes; %0d result items checked over four idle phases and one hold-off",
             n_finishes, n_results);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // input driver
  always @(posedge clk) begin
    int send_gap_pct;
    send_gap_pct = (idle_phase == 1) ? 54 : (idle_phase == 3) ? 8 : 0;
    if (rst) begin
      search_in.valid <= 1'b0;
      clear_search_state();
    end else begin
      if (search_in.valid && search_in.ready) begin
        track_search(cur_item);
        n_sent++;
        idle_phase = (n_sent * 4) / total_items;
      end
      if (!search_in.valid || search_in.ready) begin
        // a drain item waits until every expected exit has come back
        if (search_q.size() != 0 && $urandom_range(99) >= send_gap_pct
            && !(search_q[0].drain && exit_q.size() != 0)) begin
          cur_item = search_q.pop_front();
          search_in.action            <= cur_item.action;
          search_in.mode              <= cur_item.mode;
          search_in.anchor_norm_sq    <= cur_item.a_nsq;
          search_in.anchor_dot_dir    <= cur_item.a_dir;
          search_in.anchor_dot_origin <= cur_item.a_org;
          search_in.fwd_limit         <= cur_item.fwd_lim;
          search_in.bwd_limit         <= cur_item.bwd_lim;
          search_in.cand_index        <= cur_item.idx;
          search_in.cand_norm_sq      <= cur_item.c_nsq;
          search_in.cand_dot_dir      <= cur_item.c_dir;
          search_in.cand_dot_origin   <= cur_item.c_org;
          search_in.cand_ignored      <= cur_item.ignored;
          search_in.valid             <= 1'b1;
        end else begin
          search_in.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    int stall_pct;
    stall_pct = (idle_phase == 2) ? 54 : (idle_phase == 3) ? 8 : 0;
    if (rst) begin
      search_out.ready <= 1'b0;
      holdoff_left = 0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      search_out.ready <= 1'b0;
    end else if (!holdoff_used && n_results >= 30) begin
      holdoff_used = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      search_out.ready <= 1'b0;
    end else begin
      search_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    exit_result_t want;
    if (!rst && search_out.valid && search_out.ready) begin
      n_results++;
      if (exit_q.size() == 0) begin
        report_mismatch("unexpected result item", search_out.primary_length, '0);
      end else begin
        want = exit_q.pop_front();
        check_field("primary_found", search_out.primary_found, want.p_found);
        check_field("primary_index", search_out.primary_index, want.p_idx);
        check_field("primary_length", search_out.primary_length, want.p_len);
        check_field("second_found", search_out.second_found, want.s_found);
        check_field("second_index", search_out.second_index, want.s_idx);
        check_field("second_length", search_out.second_length, want.s_len);
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (search_in.valid && search_in.ready) || (search_out.valid && search_out.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
